// ===== design/sbs_pkg.sv =====
package sbs_pkg;

    // Sizes
    localparam int MAX_EXPR_BYTES = 4096;
    localparam int DEPTH_BITS     = 16;
    localparam int KEEP_W         = $clog2(MAX_EXPR_BYTES);

    // Scanner phase
    typedef enum logic [1:0] {
        PH_SKIP    = 2'd0,
        PH_COMMENT = 2'd1,
        PH_BODY    = 2'd2
    } phase_t;

    // Result event codes
    typedef enum logic [1:0] {
        EV_CONT = 2'd0,
        EV_DONE = 2'd1,
        EV_NONE = 2'd2,
        EV_OPEN = 2'd3
    } event_t;

    typedef logic [DEPTH_BITS-1:0] depth_t;
    typedef logic [KEEP_W-1:0]     count_t;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

// ===== design/sbs_if.sv =====
// Input byte channel
interface sbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

// Result channel
interface sbs_out_if;
    logic       valid;
    logic       ready;
    logic       keep_char;
    logic [7:0] char_out;
    logic [1:0] event_res;
    logic       depth_overflow;

    modport source (output valid, output keep_char, output char_out, output event_res,
                    output depth_overflow, input ready);
    modport sink   (input valid, input keep_char, input char_out, input event_res,
                    input depth_overflow, output ready);
endinterface

// ===== design/sexpr_boundary_scanner_unit.sv =====
// S-expression boundary scanner.
// byte_stream carries one byte (char_in) or an end-of-input mark per transfer.
// result returns exactly one item per input transfer: keep_char says whether
// the byte is part of the current top-level expression, char_out echoes it,
// event_res marks expression complete, end with no expression, or end inside
// an unfinished expression, and depth_overflow flags a '(' at full depth.
// The result is registered: it is valid in the cycle after the input transfer.
// Throughput: one byte per cycle when not stalled; all decoding is a single
// pass from the scanner state and the incoming byte into the result register.
// A stalled result holds in the result register; byte_stream.ready drops
// only while that register is full and result.ready is low, so no byte is
// lost and the scanner state advances only on input transfers.
// Reset (rst_n low, asynchronous) returns the scanner to the skipping phase
// with depth, string, escape and kept-length state cleared, and empties the
// result register.
module sexpr_boundary_scanner_unit (
    input  logic             clk,
    input  logic             rst_n,
    sbs_in_if.sink           byte_stream,
    sbs_out_if.source        result
);

    localparam sbs_pkg::depth_t DEPTH_MAX = '1;
    localparam sbs_pkg::count_t KEEP_LIMIT = sbs_pkg::KEEP_W'(sbs_pkg::MAX_EXPR_BYTES - 1);

    // Scanner state
    sbs_pkg::phase_t phase_reg, phase_next;
    sbs_pkg::depth_t depth_reg, depth_next;
    logic            str_reg, str_next;
    logic            esc_reg, esc_next;
    sbs_pkg::count_t count_reg, count_next;

    // Result register
    logic            out_valid_reg;
    logic            keep_reg, keep_next;
    logic [7:0]      char_reg, char_next;
    sbs_pkg::event_t ev_reg, ev_next;
    logic            ovf_reg, ovf_next;

    logic            in_xfer;
    logic [7:0]      c;
    logic            eoi;
    logic            is_ws;
    logic            is_break;
    sbs_pkg::phase_t eff_phase;

    // Body decode results
    logic            b_keep;
    logic            b_ended;
    logic            b_ovf;
    sbs_pkg::depth_t b_depth;
    logic            b_str;
    logic            b_esc;
    sbs_pkg::count_t count_inc;

    assign c       = byte_stream.char_in;
    assign eoi     = byte_stream.end_of_input;
    assign byte_stream.ready = !out_valid_reg || result.ready;
    assign in_xfer = byte_stream.valid && byte_stream.ready;

    assign is_ws    = (c == sbs_pkg::CH_SPACE) || (c >= sbs_pkg::CH_TAB && c <= sbs_pkg::CH_CR);
    assign is_break = (c == sbs_pkg::CH_SPACE) || (c == sbs_pkg::CH_TAB) ||
                      (c == sbs_pkg::CH_LF) || (c == sbs_pkg::CH_CR);
    assign count_inc = count_reg + 1'b1;

    // Phase after leading whitespace / comment handling of this byte
    always_comb
    begin
        unique case (phase_reg)
            sbs_pkg::PH_COMMENT:
            begin
                eff_phase = (c == sbs_pkg::CH_LF || c == sbs_pkg::CH_CR) ?
                            sbs_pkg::PH_SKIP : sbs_pkg::PH_COMMENT;
            end
            sbs_pkg::PH_BODY:
            begin
                eff_phase = sbs_pkg::PH_BODY;
            end
            default:
            begin
                if (c == sbs_pkg::CH_SEMI)
                    eff_phase = sbs_pkg::PH_COMMENT;
                else if (is_ws)
                    eff_phase = sbs_pkg::PH_SKIP;
                else
                    eff_phase = sbs_pkg::PH_BODY;
            end
        endcase
    end

    // Body byte: escape, string, depth and end detection
    always_comb
    begin
        b_keep  = 1'b1;
        b_ended = 1'b0;
        b_ovf   = 1'b0;
        b_depth = depth_reg;
        b_str   = str_reg;
        b_esc   = 1'b0;
        if (esc_reg)
        begin
            b_esc = 1'b0;
        end
        else if (c == sbs_pkg::CH_BSLASH && str_reg)
        begin
            b_esc = 1'b1;
        end
        else if (c == sbs_pkg::CH_QUOTE)
        begin
            b_str = !str_reg;
        end
        else if (!str_reg)
        begin
            if (c == sbs_pkg::CH_LPAREN)
            begin
                if (depth_reg == DEPTH_MAX)
                    b_ovf = 1'b1;
                else
                    b_depth = depth_reg + 1'b1;
            end
            else if (c == sbs_pkg::CH_RPAREN)
            begin
                // unmatched ')' or return to top level ends the expression
                b_ended = (depth_reg == '0) || (depth_reg == sbs_pkg::depth_t'(1));
                if (depth_reg != '0)
                    b_depth = depth_reg - 1'b1;
            end
            else if (depth_reg == '0 && is_break)
            begin
                b_keep  = 1'b0;
                b_ended = 1'b1;
            end
        end
        // length limit
        if (b_keep && count_inc >= KEEP_LIMIT)
            b_ended = 1'b1;
    end

    // Next scanner state
    always_comb
    begin
        phase_next = phase_reg;
        depth_next = depth_reg;
        str_next   = str_reg;
        esc_next   = esc_reg;
        count_next = count_reg;
        if (eoi)
        begin
            if (phase_reg == sbs_pkg::PH_BODY)
            begin
                phase_next = sbs_pkg::PH_SKIP;
                depth_next = '0;
                str_next   = 1'b0;
                esc_next   = 1'b0;
                count_next = '0;
            end
        end
        else if (eff_phase != sbs_pkg::PH_BODY)
        begin
            phase_next = eff_phase;
        end
        else if (b_ended)
        begin
            phase_next = sbs_pkg::PH_SKIP;
            depth_next = '0;
            str_next   = 1'b0;
            esc_next   = 1'b0;
            count_next = '0;
        end
        else
        begin
            phase_next = sbs_pkg::PH_BODY;
            depth_next = b_depth;
            str_next   = b_str;
            esc_next   = b_esc;
            count_next = count_inc;
        end
    end

    // Result values
    always_comb
    begin
        keep_next = 1'b0;
        char_next = c;
        ev_next   = sbs_pkg::EV_CONT;
        ovf_next  = 1'b0;
        if (eoi)
        begin
            char_next = '0;
            if (phase_reg == sbs_pkg::PH_BODY)
                ev_next = (depth_reg == '0 && !str_reg) ? sbs_pkg::EV_DONE : sbs_pkg::EV_OPEN;
            else
                ev_next = sbs_pkg::EV_NONE;
        end
        else if (eff_phase == sbs_pkg::PH_BODY)
        begin
            keep_next = b_keep;
            ovf_next  = b_ovf;
            ev_next   = b_ended ? sbs_pkg::EV_DONE : sbs_pkg::EV_CONT;
        end
    end

    // Scanner state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sbs_pkg::PH_SKIP;
            depth_reg <= '0;
            str_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            count_reg <= '0;
        end
        else if (in_xfer)
        begin
            phase_reg <= phase_next;
            depth_reg <= depth_next;
            str_reg   <= str_next;
            esc_reg   <= esc_next;
            count_reg <= count_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (byte_stream.ready)
            out_valid_reg <= byte_stream.valid;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            keep_reg <= keep_next;
            char_reg <= char_next;
            ev_reg   <= ev_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.keep_char      = keep_reg;
    assign result.char_out       = char_reg;
    assign result.event_res      = ev_reg;
    assign result.depth_overflow = ovf_reg;

endmodule

// ===== design/sbs_checker.sv =====
module sbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       keep_char,
    input logic [7:0] char_out,
    input logic [1:0] event_res,
    input logic       depth_overflow
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out) &&
        $stable(keep_char) && $stable(event_res) && $stable(depth_overflow))
        else $error("stalled result changed");

    // every input transfer yields a result next cycle
    a_one_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after input transfer");

    // a full, stalled result register blocks input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // overflow only on a kept open paren
    a_ovf_paren: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && depth_overflow |-> keep_char && char_out == sbs_pkg::CH_LPAREN)
        else $error("depth overflow on non-paren byte");

    // kept byte never reports end with no expression or an unfinished end
    a_keep_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && keep_char |-> event_res != sbs_pkg::EV_NONE &&
        event_res != sbs_pkg::EV_OPEN)
        else $error("kept byte with end-of-input event");

endmodule

bind sexpr_boundary_scanner_unit sbs_checker u_sbs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (byte_stream.valid),
    .in_ready       (byte_stream.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .keep_char      (result.keep_char),
    .char_out       (result.char_out),
    .event_res      (result.event_res),
    .depth_overflow (result.depth_overflow)
);

// ===== bench/testbench.sv =====
module testbench;

    localparam int              LIMIT_CYCLES = 4_000_000;
    localparam int              RANDOM_ITEMS = 1850;
    localparam logic [7:0]      CH_VT        = 8'h0B;
    localparam logic [7:0]      CH_FF        = 8'h0C;
    localparam sbs_pkg::depth_t DEPTH_FULL   = '1;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } byte_item_t;

    typedef struct packed {
        logic            keep;
        logic [7:0]      ch;
        sbs_pkg::event_t ev;
        logic            ovf;
    } scan_res_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sbs_in_if  bs ();
    sbs_out_if res ();

    sexpr_boundary_scanner_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (bs),
        .result      (res)
    );

    always #5 clk = ~clk;

    // Bytes waiting to be sent, and scan results waiting to come back
    byte_item_t byte_q[$];
    scan_res_t  scan_q[$];

    // Scanner state as the bench tracks it
    sbs_pkg::phase_t sc_phase;
    sbs_pkg::depth_t sc_depth;
    logic            sc_in_str;
    logic            sc_esc;
    int              sc_kept;

    int n_directed;
    int n_fail;
    int n_results;
    int n_done;
    int n_none;
    int n_open;
    int n_kept;
    int n_cut;
    int deepest;
    int cycle_cnt;

    // Stimulus building
    function automatic void add_byte(input logic [7:0] c);
        byte_q.push_back('{ch: c, eoi: 1'b0});
    endfunction

    function automatic void add_eoi();
        byte_q.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 5))
            0:       return sbs_pkg::CH_TAB;
            1:       return sbs_pkg::CH_LF;
            2:       return CH_VT;
            3:       return CH_FF;
            4:       return sbs_pkg::CH_CR;
            default: return sbs_pkg::CH_SPACE;
        endcase
    endfunction

    // Printable or high byte that never opens a list, string or comment
    function automatic logic [7:0] atom_char();
        logic [7:0] c;
        c = 8'($urandom_range(33, 255));
        while (c == sbs_pkg::CH_LPAREN || c == sbs_pkg::CH_RPAREN ||
               c == sbs_pkg::CH_QUOTE || c == sbs_pkg::CH_SEMI)
            c = 8'($urandom_range(33, 255));
        return c;
    endfunction

    function automatic void add_atom(input int len);
        for (int i = 0; i < len; i++)
            add_byte(atom_char());
    endfunction

    // Quoted text with escapes; an escape may protect any byte
    function automatic void add_string(input bit close);
        int len;
        len = $urandom_range(0, 8);
        add_byte(sbs_pkg::CH_QUOTE);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                add_byte(sbs_pkg::CH_BSLASH);
                add_byte(8'($urandom_range(0, 255)));
            end
            else if ($urandom_range(0, 5) == 0)
                add_byte(sbs_pkg::CH_SPACE);
            else
                add_byte(atom_char());
        end
        if (close)
            add_byte(sbs_pkg::CH_QUOTE);
    endfunction

    // Nested list; when cut short it stops with open parentheses
    function automatic void add_list(input int max_steps, input bit finish);
        int depth;
        int steps;
        int r;
        logic [7:0] c;
        add_byte(sbs_pkg::CH_LPAREN);
        depth = 1;
        steps = 0;
        while (depth > 0 && (finish || steps < max_steps))
        begin
            r = (steps >= max_steps) ? 2 : $urandom_range(0, 11);
            case (r)
                0, 1:
                begin
                    if (depth < 6)
                    begin
                        add_byte(sbs_pkg::CH_LPAREN);
                        depth++;
                    end
                    else
                        add_atom(1);
                end
                2, 3:
                begin
                    add_byte(sbs_pkg::CH_RPAREN);
                    depth--;
                end
                4, 5, 6: add_atom($urandom_range(1, 6));
                7:       add_string(1'b1);
                8:       add_byte(ws_char());
                9:       add_byte(sbs_pkg::CH_SEMI);
                10:
                begin
                    c = 8'($urandom_range(0, 255));
                    if (c == sbs_pkg::CH_QUOTE || c == sbs_pkg::CH_LPAREN ||
                        c == sbs_pkg::CH_RPAREN)
                        c = "x";
                    add_byte(c);
                end
                default: add_byte(sbs_pkg::CH_SPACE);
            endcase
            steps++;
        end
    endfunction

    // Whatever may follow an expression at top level
    function automatic void add_gap_text();
        int len;
        case ($urandom_range(0, 7))
            0, 1, 2: add_byte($urandom_range(0, 1) ? sbs_pkg::CH_SPACE : sbs_pkg::CH_LF);
            3:
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    add_byte(ws_char());
            end
            4:
            begin
                add_byte(sbs_pkg::CH_SEMI);
                len = $urandom_range(0, 10);
                for (int i = 0; i < len; i++)
                    add_byte(atom_char());
                add_byte($urandom_range(0, 1) ? sbs_pkg::CH_CR : sbs_pkg::CH_LF);
            end
            5:       add_eoi();
            6:       add_byte(sbs_pkg::CH_TAB);
            default: ;
        endcase
    endfunction

    // Gap length: mostly none or short, rarely long, with idle-free bursts
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            burst = $urandom_range(20, 150);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    // Scanner prediction
    function automatic void clear_scan();
        sc_phase  = sbs_pkg::PH_SKIP;
        sc_depth  = '0;
        sc_in_str = 1'b0;
        sc_esc    = 1'b0;
        sc_kept   = 0;
    endfunction

    function automatic scan_res_t scan_byte(input logic [7:0] c, input logic eoi);
        scan_res_t r;
        logic      ended;
        r = '{keep: 1'b0, ch: 8'h00, ev: sbs_pkg::EV_CONT, ovf: 1'b0};
        ended = 1'b0;

        // End mark: only the event carries information
        if (eoi)
        begin
            if (sc_phase == sbs_pkg::PH_BODY)
            begin
                r.ev = (sc_depth == '0 && !sc_in_str) ? sbs_pkg::EV_DONE : sbs_pkg::EV_OPEN;
                clear_scan();
            end
            else
                r.ev = sbs_pkg::EV_NONE;
            return r;
        end
        r.ch = c;

        // Phase change first, so the byte that leaves skipping is a body byte
        if (sc_phase == sbs_pkg::PH_COMMENT)
        begin
            if (c == sbs_pkg::CH_LF || c == sbs_pkg::CH_CR)
                sc_phase = sbs_pkg::PH_SKIP;
        end
        else if (sc_phase != sbs_pkg::PH_BODY)
        begin
            if (c == sbs_pkg::CH_SEMI)
                sc_phase = sbs_pkg::PH_COMMENT;
            else if (!(c == sbs_pkg::CH_SPACE ||
                       (c >= sbs_pkg::CH_TAB && c <= sbs_pkg::CH_CR)))
                sc_phase = sbs_pkg::PH_BODY;
        end

        // Body: strings, escapes, nesting and top-level breaks
        if (sc_phase == sbs_pkg::PH_BODY)
        begin
            r.keep = 1'b1;
            sc_kept++;
            if (sc_esc)
                sc_esc = 1'b0;
            else if (c == sbs_pkg::CH_BSLASH && sc_in_str)
                sc_esc = 1'b1;
            else if (c == sbs_pkg::CH_QUOTE)
                sc_in_str = !sc_in_str;
            else if (!sc_in_str)
            begin
                if (c == sbs_pkg::CH_LPAREN)
                begin
                    if (sc_depth == DEPTH_FULL)
                        r.ovf = 1'b1;
                    else
                        sc_depth++;
                    if (int'(sc_depth) > deepest)
                        deepest = int'(sc_depth);
                end
                else if (c == sbs_pkg::CH_RPAREN)
                begin
                    // an unmatched close also ends the expression
                    if (sc_depth != '0)
                        sc_depth--;
                    ended = (sc_depth == '0);
                end
                else if (sc_depth == '0 &&
                         (c == sbs_pkg::CH_SPACE || c == sbs_pkg::CH_TAB ||
                          c == sbs_pkg::CH_LF || c == sbs_pkg::CH_CR))
                begin
                    r.keep = 1'b0;
                    sc_kept--;
                    ended = 1'b1;
                end
            end
            if (!ended && sc_kept >= sbs_pkg::MAX_EXPR_BYTES - 1)
            begin
                ended = 1'b1;
                n_cut++;
            end
            if (ended)
            begin
                r.ev = sbs_pkg::EV_DONE;
                clear_scan();
            end
        end
        return r;
    endfunction

    // Byte driver
    int src_gap;
    int src_burst;

    always @(posedge clk)
    begin : byte_driver
        byte_item_t it;
        if (!rst_n)
        begin
            bs.valid        <= 1'b0;
            bs.char_in      <= '0;
            bs.end_of_input <= 1'b0;
            src_gap   = 0;
            src_burst = 0;
        end
        else if (!bs.valid || bs.ready)
        begin
            if (src_gap > 0)
            begin
                bs.valid <= 1'b0;
                src_gap--;
            end
            else if (byte_q.size() > 0)
            begin
                it = byte_q.pop_front();
                bs.valid        <= 1'b1;
                bs.char_in      <= it.ch;
                bs.end_of_input <= it.eoi;
                src_gap = pick_gap(src_burst);
            end
            else
                bs.valid <= 1'b0;
        end
    end

    // Result receiver, with one long hold-off to back up the input
    int  snk_gap;
    int  snk_burst;
    int  snk_xfers;
    int  hold_left;
    bit  hold_done;

    always @(posedge clk)
    begin : result_receiver
        logic rdy;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            snk_gap   = 0;
            snk_burst = 0;
            snk_xfers = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (res.valid && res.ready)
                snk_xfers++;
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (!hold_done && snk_xfers >= 400)
            begin
                hold_left = 300;
                hold_done = 1'b1;
                rdy = 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
                if (res.valid && res.ready)
                    snk_gap = pick_gap(snk_burst);
            end
            res.ready <= rdy;
        end
    end

    // Monitor: predict on each byte transfer, check each result transfer
    always @(posedge clk)
    begin : scan_monitor
        scan_res_t want;
        if (rst_n)
        begin
            if (bs.valid && bs.ready)
                scan_q.push_back(scan_byte(bs.char_in, bs.end_of_input));
            if (res.valid && res.ready)
            begin
                n_results++;
                if (scan_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected result %0d: keep=%0b char=%02h event=%0d ovf=%0b",
                                 n_results, res.keep_char, res.char_out, res.event_res,
                                 res.depth_overflow);
                end
                else
                begin
                    want = scan_q.pop_front();
                    if (res.keep_char !== want.keep || res.char_out !== want.ch ||
                        res.event_res !== want.ev || res.depth_overflow !== want.ovf)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display({"mismatch at result %0d: expected keep=%0b char=%02h ",
                                      "event=%s ovf=%0b, got keep=%0b char=%02h event=%0d ",
                                      "ovf=%0b"},
                                     n_results, want.keep, want.ch, want.ev.name(), want.ovf,
                                     res.keep_char, res.char_out, res.event_res,
                                     res.depth_overflow);
                    end
                    case (want.ev)
                        sbs_pkg::EV_DONE: n_done++;
                        sbs_pkg::EV_NONE: n_none++;
                        sbs_pkg::EV_OPEN: n_open++;
                        default: ;
                    endcase
                    if (want.keep)
                        n_kept++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, scan_q.size());
            $display("sexpr_boundary_scanner_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        bs.valid        = 1'b0;
        bs.char_in      = '0;
        bs.end_of_input = 1'b0;
        res.ready       = 1'b0;
        clear_scan();

        // Directed: end mark while idle, whitespace, a comment
        add_eoi();
        add_byte(sbs_pkg::CH_SPACE);
        add_byte(sbs_pkg::CH_TAB);
        add_byte(CH_VT);
        add_byte(CH_FF);
        add_byte(sbs_pkg::CH_SEMI);
        add_byte(8'hFF);
        add_byte(sbs_pkg::CH_CR);
        // list holding a string with an escaped quote and paren
        add_byte(sbs_pkg::CH_LPAREN);
        add_byte(sbs_pkg::CH_QUOTE);
        add_byte(sbs_pkg::CH_BSLASH);
        add_byte(sbs_pkg::CH_QUOTE);
        add_byte(sbs_pkg::CH_RPAREN);
        add_byte(sbs_pkg::CH_QUOTE);
        add_byte(sbs_pkg::CH_RPAREN);
        add_byte(sbs_pkg::CH_LF);
        // unmatched close, atom ended by a space, unfinished list, atom at end
        add_byte(sbs_pkg::CH_RPAREN);
        add_byte(8'h00);
        add_byte(sbs_pkg::CH_SPACE);
        add_byte(sbs_pkg::CH_LPAREN);
        add_eoi();
        add_byte("b");
        add_eoi();
        // open string at end, end mark inside a comment
        add_byte(sbs_pkg::CH_QUOTE);
        add_eoi();
        add_byte(sbs_pkg::CH_SEMI);
        add_eoi();
        add_byte(sbs_pkg::CH_LF);
        n_directed = byte_q.size();

        // Random: mostly well-formed text, some noise and cut-off expressions
        while (byte_q.size() < n_directed + RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                add_list($urandom_range(1, 24), 1'b1);
                add_gap_text();
            end
            else if (r < 67)
            begin
                add_atom($urandom_range(1, 8));
                add_gap_text();
            end
            else if (r < 72)
            begin
                add_string(1'b1);
                add_gap_text();
            end
            else if (r < 78)
                add_gap_text();
            else if (r < 86)
            begin
                for (int i = $urandom_range(1, 8); i > 0; i--)
                    if ($urandom_range(0, 7) == 0)
                        add_eoi();
                    else
                        add_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 94)
            begin
                if ($urandom_range(0, 2) == 0)
                    add_string(1'b0);
                else
                    add_list($urandom_range(1, 10), 1'b0);
                add_eoi();
            end
            else
                add_eoi();
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all bytes sent and every result back, then let the pipe settle
        @(negedge clk);
        while (byte_q.size() != 0 || bs.valid || scan_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (scan_q.size() != 0)
            n_fail++;

        $display("%0d directed and %0d random bytes or end marks; %0d results, %0d kept",
                 n_directed, n_results - n_directed, n_results, n_kept);
        $display("%0d complete, %0d empty ends, %0d unfinished, %0d length cuts, depth %0d",
                 n_done, n_none, n_open, n_cut, deepest);
        if (n_fail == 0)
            $display("sexpr_boundary_scanner_unit verification clean");
        else
            $display("sexpr_boundary_scanner_unit verification failed");
        $finish;
    end

endmodule
